FILE: hw/rtl/wcn_pkg.sv
// Shared types, constants and tables for the weighted corner normal block.
// No dependencies.
`default_nettype none

package wcn_pkg;

  localparam int MAX_CORNERS_DEF = 16;
  localparam int COORD_W         = 24;
  localparam int TOL_W           = 48;
  localparam int NORM_W          = 64;
  localparam int MAC_OP_W        = 33;
  localparam int ACC_W           = 66;
  localparam int CORD_W          = 31;

  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef struct packed {
    logic issue;
    logic sub;
    logic clr;
  } mac_ctl_t;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  // magnitude shift: left for positive amounts, truncating right otherwise
  function automatic logic [63:0] shmag(input logic [63:0] v, input logic signed [7:0] sh);
    logic [7:0] amt;
    logic [63:0] r;
    amt = sh[7] ? 8'(-sh) : 8'(sh);
    if (amt >= 8'd64) r = '0;
    else if (sh[7]) r = v >> amt[5:0];
    else r = v << amt[5:0];
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/wcn_mac.sv
// Shared multiply-accumulate unit: registered 33x33 product, then accumulate.
// Depends on wcn_pkg.
`default_nettype none

module wcn_mac import wcn_pkg::*; (
  input  wire                          clk,
  input  wire                          rst_n,
  input  mac_ctl_t                     ctl,
  input  wire logic signed [MAC_OP_W-1:0] op_a,
  input  wire logic signed [MAC_OP_W-1:0] op_b,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [ACC_W-1:0] prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic                    sub_r;
  logic                    pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= ctl.issue && !ctl.clr;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      prod_r <= op_a * op_b;
      sub_r  <= ctl.sub;
    end
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (pend_r) begin
      acc_r <= sub_r ? acc_r - prod_r : acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

FILE: hw/rtl/wcn_cordic.sv
// Iterative CORDIC vectoring, one micro-rotation per cycle.
// Depends on wcn_pkg for the arctangent table.
`default_nettype none

module wcn_cordic import wcn_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire logic [CORD_W-1:0] a_in,
  input  wire logic [CORD_W-1:0] b_in,
  output logic                   busy,
  output logic [CORD_W-1:0]      z_out
);

  logic signed [35:0] x_r, y_r, xs, ys;
  logic signed [33:0] z_r, at;
  logic [4:0]         i_r;
  logic               busy_r;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign at = signed'(34'(atan_q30(i_r)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && i_r == 5'd31) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= 36'(a_in);
      y_r <= 36'(b_in);
      z_r <= '0;
      i_r <= '0;
    end else if (busy_r) begin
      if (!y_r[35]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
      i_r <= i_r + 5'd1;
    end
  end

  always_comb begin
    if (z_r[33]) z_out = '0;
    else if (z_r > signed'(34'(HALF_PI_Q30))) z_out = HALF_PI_Q30;
    else z_out = z_r[CORD_W-1:0];
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

FILE: hw/rtl/weighted_corner_normal_top.sv
// Corner normal of one polygon facet: corner store, sequencer and iterative units.
// Loading takes one corner per cycle; then come the neighbour walk, the cross product and,
// outside area mode, a leading-one scan, a root and three divisions; angle mode adds a dot
// product, a second leading-one scan, the CORDIC and three scalings.
// Throughput: one facet per load plus compute time; one output word buffered.
// Reset (synchronous): control and config cleared; corner store contents undefined.
`default_nettype none

module weighted_corner_normal_top import wcn_pkg::*; #(
  parameter int MAX_CORNERS = MAX_CORNERS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  wire logic [COORD_W-1:0]  in_pos_x,
  input  wire logic [COORD_W-1:0]  in_pos_y,
  input  wire logic [COORD_W-1:0]  in_pos_z,
  input  wire                      in_is_target,
  input  wire                      in_last_corner,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [NORM_W-1:0]        out_normal_x,
  output logic [NORM_W-1:0]        out_normal_y,
  output logic [NORM_W-1:0]        out_normal_z,
  input  wire                      cfg_we,
  input  wire                      cfg_index,
  input  wire logic [TOL_W-1:0]    cfg_wdata
);

  localparam int IW = $clog2(MAX_CORNERS);
  localparam int CW = $clog2(MAX_CORNERS + 1);
  localparam int BW = 51;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_TOL  = 1'b1;

  localparam logic [1:0] MODE_AREA  = 2'd1;
  localparam logic [1:0] MODE_ANGLE = 2'd2;

  localparam logic [2:0] OP_SQD = 3'd0;
  localparam logic [2:0] OP_CRS = 3'd1;
  localparam logic [2:0] OP_DOT = 3'd2;
  localparam logic [2:0] OP_NSQ = 3'd3;
  localparam logic [2:0] OP_SC  = 3'd4;

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_RDT   = 5'd1;
  localparam logic [4:0] S_GETT  = 5'd2;
  localparam logic [4:0] S_NXCHK = 5'd3;
  localparam logic [4:0] S_NXGET = 5'd4;
  localparam logic [4:0] S_NXCMP = 5'd5;
  localparam logic [4:0] S_PVCHK = 5'd6;
  localparam logic [4:0] S_PVGET = 5'd7;
  localparam logic [4:0] S_PVCMP = 5'd8;
  localparam logic [4:0] S_FIX   = 5'd9;
  localparam logic [4:0] S_RDN   = 5'd10;
  localparam logic [4:0] S_RDP   = 5'd11;
  localparam logic [4:0] S_GETP  = 5'd12;
  localparam logic [4:0] S_CRS   = 5'd13;
  localparam logic [4:0] S_MODE  = 5'd14;
  localparam logic [4:0] S_NPS   = 5'd15;
  localparam logic [4:0] S_SQI   = 5'd16;
  localparam logic [4:0] S_SQA   = 5'd17;
  localparam logic [4:0] S_SQB   = 5'd18;
  localparam logic [4:0] S_DVI   = 5'd19;
  localparam logic [4:0] S_DVS   = 5'd20;
  localparam logic [4:0] S_DVD   = 5'd21;
  localparam logic [4:0] S_DOT   = 5'd22;
  localparam logic [4:0] S_DTB   = 5'd23;
  localparam logic [4:0] S_ANG   = 5'd24;
  localparam logic [4:0] S_CWT   = 5'd25;
  localparam logic [4:0] S_SCS   = 5'd26;
  localparam logic [4:0] S_OUT   = 5'd27;
  localparam logic [4:0] S_MAC   = 5'd28;
  localparam logic [4:0] S_BLN   = 5'd29;

  // config
  logic [1:0]       mode_r;
  logic [TOL_W-1:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      tol_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE: mode_r <= cfg_wdata[1:0];
        CFG_TOL:  tol_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // corner store
  logic [71:0]   mem [MAX_CORNERS];
  logic [71:0]   mem_q;
  logic [IW-1:0] rd_addr;

  logic [4:0]    state_r, ret_r;
  logic [CW-1:0] cnt_r, cnt_f_r, cnt_new;
  logic [IW-1:0] t_r, t_f_r, nx_r, pv_r;
  logic          in_acc, full;

  assign in_ready = (state_r == S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign full     = (cnt_r == CW'(MAX_CORNERS));
  assign cnt_new  = full ? cnt_r : cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      mem[cnt_r[IW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    end
    mem_q <= mem[rd_addr];
  end

  // neighbour index arithmetic
  logic [CW-1:0] t1, n1;
  logic [IW-1:0] ninit, pinit, nnext, pnext;
  logic          tri_f;

  assign t1    = CW'(t_f_r) + 1'b1;
  assign n1    = CW'(nx_r) + 1'b1;
  assign ninit = (t1 == cnt_f_r) ? '0 : t1[IW-1:0];
  assign pinit = (t_f_r == '0) ? IW'(cnt_f_r - 1'b1) : t_f_r - 1'b1;
  assign nnext = (n1 == cnt_f_r) ? '0 : n1[IW-1:0];
  assign pnext = (pv_r == '0) ? IW'(cnt_f_r - 1'b1) : pv_r - 1'b1;
  assign tri_f = (cnt_f_r == CW'(3));

  always_comb begin
    unique case (state_r)
      S_NXCHK, S_RDN: rd_addr = nx_r;
      S_PVCHK, S_RDP: rd_addr = pv_r;
      default:        rd_addr = t_f_r;
    endcase
  end

  // datapath registers
  logic [71:0]        tgt_r;
  logic signed [24:0] d_r  [3];
  logic signed [24:0] e1_r [3];
  logic signed [24:0] e2_r [3];
  logic signed [50:0] n_r  [3];
  logic [30:0]        np_r [3];
  logic [30:0]        u_r  [3];
  logic [NORM_W-1:0]  res_r [3];
  logic signed [50:0] dt_r;
  logic signed [7:0]  s_r;
  logic [31:0]        len_r, theta_r;
  logic [2:0]         op_r;
  logic [1:0]         k_r, c_r, ki, nterm;
  logic [BW-1:0]      bv_r;
  logic [5:0]         blen_r;
  logic [63:0]        sx_r, sr_r, sbit_r;
  logic [60:0]        dv_r;
  logic [31:0]        rem_r;
  logic [5:0]         dk_r;

  // shared multiply-accumulate
  mac_ctl_t                  mctl;
  logic signed [MAC_OP_W-1:0] op_a, op_b;
  logic signed [ACC_W-1:0]   acc;
  logic [1:0]                cj, cl;

  assign ki = (k_r == 2'd3) ? 2'd2 : k_r;

  always_comb begin
    unique case (c_r)
      2'd0:    begin cj = 2'd1; cl = 2'd2; end
      2'd1:    begin cj = 2'd2; cl = 2'd0; end
      default: begin cj = 2'd0; cl = 2'd1; end
    endcase
  end

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    nterm = 2'd3;
    mctl.sub = 1'b0;
    unique case (op_r)
      OP_SQD: begin
        op_a = MAC_OP_W'(d_r[ki]);
        op_b = MAC_OP_W'(d_r[ki]);
      end
      OP_CRS: begin
        nterm = 2'd2;
        if (k_r == 2'd0) begin
          op_a = MAC_OP_W'(e1_r[cj]);
          op_b = MAC_OP_W'(e2_r[cl]);
        end else begin
          op_a = MAC_OP_W'(e1_r[cl]);
          op_b = MAC_OP_W'(e2_r[cj]);
          mctl.sub = 1'b1;
        end
      end
      OP_DOT: begin
        op_a = MAC_OP_W'(e1_r[ki]);
        op_b = MAC_OP_W'(e2_r[ki]);
      end
      OP_NSQ: begin
        op_a = signed'({2'b0, np_r[ki]});
        op_b = signed'({2'b0, np_r[ki]});
      end
      OP_SC: begin
        nterm = 2'd1;
        op_a = signed'({2'b0, u_r[c_r]});
        op_b = signed'({1'b0, theta_r});
      end
      default: ;
    endcase
    mctl.issue = (state_r == S_MAC) && (k_r < nterm);
    mctl.clr   = (state_r == S_NXGET) || (state_r == S_PVGET) || (state_r == S_GETP) ||
                 (state_r == S_CRS) || (state_r == S_NPS) || (state_r == S_DOT) ||
                 (state_r == S_CWT) || (state_r == S_SCS);
  end

  wcn_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mctl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  // CORDIC
  logic                cor_start, cor_busy;
  logic [CORD_W-1:0]   cor_a, cor_b, cor_z;

  wcn_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .a_in  (cor_a),
    .b_in  (cor_b),
    .busy  (cor_busy),
    .z_out (cor_z)
  );

  // combinational helpers
  logic [50:0]       nmag [3];
  logic [50:0]       mmax, dmag;
  logic              tol_le;
  logic signed [7:0] s_c, ba, bl, mx, tt;
  logic [32:0]       rem2;
  logic              dge;
  logic [64:0]       strial;
  logic [31:0]       scr;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      nmag[c] = n_r[c][50] ? 51'(-n_r[c]) : 51'(n_r[c]);
    end
    mmax = nmag[0];
    if (nmag[1] > mmax) mmax = nmag[1];
    if (nmag[2] > mmax) mmax = nmag[2];
  end

  assign dmag   = dt_r[50] ? 51'(-dt_r) : 51'(dt_r);
  assign tol_le = acc[51:0] <= {4'b0, tol_r};
  assign s_c    = 8'sd31 - signed'({2'b0, blen_r});
  assign ba     = signed'({2'b0, blen_r});
  assign bl     = (len_r[31] ? 8'sd32 : 8'sd31) - s_r;
  assign mx     = (ba > bl) ? ba : bl;
  assign tt     = 8'sd31 - mx;
  assign cor_a  = CORD_W'(shmag({13'b0, dmag}, tt));
  assign cor_b  = CORD_W'(shmag({32'b0, len_r}, tt - s_r));
  assign cor_start = (state_r == S_ANG);
  assign rem2   = {rem_r, dv_r[60]};
  assign dge    = rem2 >= {1'b0, len_r};
  assign strial = {1'b0, sr_r} + {1'b0, sbit_r};
  assign scr    = acc[61:30];

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      t_r     <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (in_last_corner) begin
              cnt_f_r <= cnt_new;
              t_f_r   <= (!full && in_is_target) ? cnt_r[IW-1:0] : t_r;
              cnt_r   <= '0;
              t_r     <= '0;
              state_r <= S_RDT;
            end else if (!full) begin
              cnt_r <= cnt_new;
              if (in_is_target) t_r <= cnt_r[IW-1:0];
            end
          end
        end
        S_RDT: begin
          nx_r    <= ninit;
          pv_r    <= pinit;
          state_r <= S_GETT;
        end
        S_GETT: begin
          tgt_r   <= mem_q;
          state_r <= S_NXCHK;
        end
        S_NXCHK: state_r <= (tri_f || nx_r == t_f_r) ? S_PVCHK : S_NXGET;
        S_NXGET, S_PVGET: begin
          for (int c = 0; c < 3; c++) begin
            d_r[c] <= 25'(signed'(mem_q[48-24*c +: 24])) -
                      25'(signed'(tgt_r[48-24*c +: 24]));
          end
          op_r    <= OP_SQD;
          k_r     <= '0;
          ret_r   <= (state_r == S_NXGET) ? S_NXCMP : S_PVCMP;
          state_r <= S_MAC;
        end
        S_NXCMP: begin
          if (tol_le) begin
            nx_r    <= nnext;
            state_r <= S_NXCHK;
          end else begin
            state_r <= S_PVCHK;
          end
        end
        S_PVCHK: state_r <= (tri_f || pv_r == t_f_r) ? S_FIX : S_PVGET;
        S_PVCMP: begin
          if (tol_le) begin
            pv_r    <= pnext;
            state_r <= S_PVCHK;
          end else begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          if (nx_r == t_f_r || pv_r == t_f_r) begin
            nx_r <= ninit;
            pv_r <= pinit;
          end
          state_r <= S_RDN;
        end
        S_RDN: state_r <= S_RDP;
        S_RDP: begin
          for (int c = 0; c < 3; c++) begin
            e1_r[c] <= 25'(signed'(mem_q[48-24*c +: 24])) -
                       25'(signed'(tgt_r[48-24*c +: 24]));
          end
          state_r <= S_GETP;
        end
        S_GETP: begin
          for (int c = 0; c < 3; c++) begin
            e2_r[c] <= 25'(signed'(mem_q[48-24*c +: 24])) -
                       25'(signed'(tgt_r[48-24*c +: 24]));
          end
          op_r    <= OP_CRS;
          k_r     <= '0;
          c_r     <= '0;
          ret_r   <= S_CRS;
          state_r <= S_MAC;
        end
        S_CRS: begin
          n_r[c_r] <= acc[50:0];
          if (c_r == 2'd2) begin
            state_r <= S_MODE;
          end else begin
            c_r     <= c_r + 2'd1;
            k_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_MODE: begin
          if (mode_r == MODE_AREA) begin
            for (int c = 0; c < 3; c++) res_r[c] <= NORM_W'(n_r[c]);
            state_r <= S_OUT;
          end else if (mmax == '0) begin
            for (int c = 0; c < 3; c++) res_r[c] <= '0;
            state_r <= S_OUT;
          end else begin
            bv_r    <= mmax;
            blen_r  <= 6'(BW);
            ret_r   <= S_NPS;
            state_r <= S_BLN;
          end
        end
        S_BLN: begin
          if (blen_r == '0 || bv_r[BW-1]) begin
            state_r <= ret_r;
          end else begin
            bv_r   <= {bv_r[BW-2:0], 1'b0};
            blen_r <= blen_r - 6'd1;
          end
        end
        S_NPS: begin
          s_r <= s_c;
          for (int c = 0; c < 3; c++) np_r[c] <= 31'(shmag({13'b0, nmag[c]}, s_c));
          op_r    <= OP_NSQ;
          k_r     <= '0;
          ret_r   <= S_SQI;
          state_r <= S_MAC;
        end
        S_SQI: begin
          sx_r    <= acc[63:0];
          sr_r    <= '0;
          sbit_r  <= 64'h4000_0000_0000_0000;
          state_r <= S_SQA;
        end
        S_SQA: begin
          if (sbit_r > sx_r) sbit_r <= sbit_r >> 2;
          else state_r <= S_SQB;
        end
        S_SQB: begin
          if (sbit_r == '0) begin
            len_r   <= sr_r[31:0];
            c_r     <= '0;
            state_r <= S_DVI;
          end else begin
            if ({1'b0, sx_r} >= strial) begin
              sx_r <= sx_r - strial[63:0];
              sr_r <= (sr_r >> 1) + sbit_r;
            end else begin
              sr_r <= sr_r >> 1;
            end
            sbit_r <= sbit_r >> 2;
          end
        end
        S_DVI: begin
          dv_r    <= {np_r[c_r], 30'b0};
          rem_r   <= '0;
          dk_r    <= '0;
          state_r <= S_DVS;
        end
        S_DVS: begin
          rem_r <= dge ? 32'(rem2 - {1'b0, len_r}) : rem2[31:0];
          dv_r  <= {dv_r[59:0], dge};
          dk_r  <= dk_r + 6'd1;
          if (dk_r == 6'd60) state_r <= S_DVD;
        end
        S_DVD: begin
          u_r[c_r]   <= dv_r[30:0];
          res_r[c_r] <= n_r[c_r][50] ? -NORM_W'(dv_r[30:0]) : NORM_W'(dv_r[30:0]);
          if (c_r == 2'd2) begin
            state_r <= (mode_r == MODE_ANGLE) ? S_DOT : S_OUT;
          end else begin
            c_r     <= c_r + 2'd1;
            state_r <= S_DVI;
          end
        end
        S_DOT: begin
          op_r    <= OP_DOT;
          k_r     <= '0;
          ret_r   <= S_DTB;
          state_r <= S_MAC;
        end
        S_DTB: begin
          dt_r    <= acc[50:0];
          bv_r    <= acc[50] ? 51'(-acc[50:0]) : acc[50:0];
          blen_r  <= 6'(BW);
          ret_r   <= S_ANG;
          state_r <= S_BLN;
        end
        S_ANG: state_r <= S_CWT;
        S_CWT: begin
          if (!cor_busy) begin
            theta_r <= dt_r[50] ? PI_Q30 - 32'(cor_z) : 32'(cor_z);
            op_r    <= OP_SC;
            k_r     <= '0;
            c_r     <= '0;
            ret_r   <= S_SCS;
            state_r <= S_MAC;
          end
        end
        S_SCS: begin
          res_r[c_r] <= n_r[c_r][50] ? -NORM_W'(scr) : NORM_W'(scr);
          if (c_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            c_r     <= c_r + 2'd1;
            k_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          k_r <= k_r + 2'd1;
          if (k_r == nterm) state_r <= ret_r;
        end
        S_OUT: begin
          if (!out_valid || out_ready) state_r <= S_LOAD;
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // output word register
  logic              out_valid_r;
  logic [NORM_W-1:0] ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
      ox_r <= res_r[0];
      oy_r <= res_r[1];
      oz_r <= res_r[2];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_normal_x = ox_r;
  assign out_normal_y = oy_r;
  assign out_normal_z = oz_r;

  // checks
  a_last_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last_corner) |=> !in_ready)
    else $error("input still taken after facet close");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_CORNERS))
    else $error("corner count overrun");

  a_tgt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOAD) |-> (CW'(t_f_r) < cnt_f_r))
    else $error("target outside facet");

  a_mac_k: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (k_r <= nterm))
    else $error("mac step overrun");

  a_nbr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDN) |-> (CW'(nx_r) < cnt_f_r && CW'(pv_r) < cnt_f_r))
    else $error("neighbour outside facet");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for weighted_corner_normal_top: directed and random facets through
// the corner port, normals predicted in-bench and checked word by word.
// Depends on wcn_pkg and the weighted_corner_normal_top RTL.
`timescale 1ns / 1ps

module tb;
  import wcn_pkg::*;

  localparam int NCORN = 16;
  localparam logic MODE_IDX = 1'b0;
  localparam logic TOL_IDX  = 1'b1;
  localparam logic [1:0] MODE_UNIFORM = 2'd0;
  localparam logic [1:0] MODE_AREA    = 2'd1;
  localparam logic [1:0] MODE_ANGLE   = 2'd2;
  localparam logic [47:0] TOL_MAX = '1;
  localparam longint PI_ANG = 64'd3373259426;
  localparam longint HALF_PI_ANG = 64'd1686629713;
  localparam int WDOG_LIMIT = 5000;
  localparam int DRAIN = 600;

  typedef struct {
    logic [23:0] x, y, z;
    logic tgt, last;
  } corner_word_t;

  typedef struct {
    longint nx, ny, nz;
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_is_target = 1'b0, in_last_corner = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [63:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [47:0] cfg_wdata = '0;

  weighted_corner_normal_top u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_pos_x, .in_pos_y, .in_pos_z,
    .in_is_target, .in_last_corner, .out_valid, .out_ready,
    .out_normal_x, .out_normal_y, .out_normal_z, .cfg_we, .cfg_index, .cfg_wdata
  );

  always #5 clk = ~clk;

  corner_word_t corner_q[$];
  normal_t normal_q[$];
  int fail_cnt = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;

  // shadow of block state
  longint sx[NCORN], sy[NCORN], sz[NCORN];
  int n_corn = 0, tgt_idx = 0;
  logic [1:0] mode_sh = MODE_UNIFORM;
  logic [47:0] tol_sh = '0;

  longint atan_tab[32] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
    64'h00000001, 64'h00000000};

  function automatic longint unsigned absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic int nbits(longint unsigned v);
    int b;
    b = 0;
    while (v != 0) begin
      b++;
      v >>= 1;
    end
    return b;
  endfunction

  function automatic longint unsigned mshift(longint unsigned v, int sh);
    if (sh >= 64 || sh <= -64) return 0;
    if (sh >= 0) return v << sh;
    return v >> (-sh);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned dist2(int a, int b);
    longint dx, dy, dz;
    dx = sx[a] - sx[b];
    dy = sy[a] - sy[b];
    dz = sz[a] - sz[b];
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic longint corner_angle(longint a, longint b);
    longint x, y, z, xs, ys;
    x = a;
    y = b;
    z = 0;
    for (int i = 0; i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_tab[i];
      end else begin
        x -= ys; y += xs; z -= atan_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > HALF_PI_ANG) z = HALF_PI_ANG;
    return z;
  endfunction

  function automatic normal_t facet_normal();
    int c, t, nx, pv, s, ba, bl, sh;
    longint e1[3], e2[3], n[3], u[3], d, theta, q;
    longint unsigned m, np[3], sum, len, a;
    normal_t r;
    c = n_corn;
    t = tgt_idx;
    nx = (t + 1 == c) ? 0 : t + 1;
    pv = (t == 0) ? c - 1 : t - 1;
    if (c != 3) begin
      while (nx != t && dist2(nx, t) <= tol_sh) nx = (nx + 1 == c) ? 0 : nx + 1;
      while (pv != t && dist2(pv, t) <= tol_sh) pv = (pv == 0) ? c - 1 : pv - 1;
    end
    if (nx == t || pv == t) begin
      nx = (t + 1 == c) ? 0 : t + 1;
      pv = (t == 0) ? c - 1 : t - 1;
    end
    e1 = '{sx[nx] - sx[t], sy[nx] - sy[t], sz[nx] - sz[t]};
    e2 = '{sx[pv] - sx[t], sy[pv] - sy[t], sz[pv] - sz[t]};
    n[0] = e1[1] * e2[2] - e1[2] * e2[1];
    n[1] = e1[2] * e2[0] - e1[0] * e2[2];
    n[2] = e1[0] * e2[1] - e1[1] * e2[0];
    if (mode_sh == MODE_AREA) begin
      r = '{n[0], n[1], n[2]};
      return r;
    end
    m = 0;
    for (int i = 0; i < 3; i++) if (absv(n[i]) > m) m = absv(n[i]);
    if (m == 0) begin
      r = '{0, 0, 0};
      return r;
    end
    s = 31 - nbits(m);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      np[i] = mshift(absv(n[i]), s);
      sum += np[i] * np[i];
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (np[i] << 30) / len;
      u[i] = n[i] < 0 ? -q : q;
    end
    if (mode_sh == MODE_ANGLE) begin
      d = e1[0] * e2[0] + e1[1] * e2[1] + e1[2] * e2[2];
      a = absv(d);
      ba = nbits(a);
      bl = nbits(len) - s;
      sh = 31 - (ba > bl ? ba : bl);
      theta = corner_angle(mshift(a, sh), mshift(len, sh - s));
      if (d < 0) theta = PI_ANG - theta;
      for (int i = 0; i < 3; i++) begin
        q = (absv(u[i]) * theta) >> 30;
        u[i] = u[i] < 0 ? -q : q;
      end
    end
    r = '{u[0], u[1], u[2]};
    return r;
  endfunction

  function automatic void load_corner(corner_word_t w);
    if (n_corn < NCORN) begin
      sx[n_corn] = {{40{w.x[23]}}, w.x};
      sy[n_corn] = {{40{w.y[23]}}, w.y};
      sz[n_corn] = {{40{w.z[23]}}, w.z};
      if (w.tgt) tgt_idx = n_corn;
      n_corn++;
    end
    if (w.last) begin
      normal_q.push_back(facet_normal());
      n_corn = 0;
      tgt_idx = 0;
    end
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  // driver
  int in_gap = 0;
  bit in_acc = 1'b0;
  always @(negedge clk) begin
    corner_word_t w;
    if (rst_n && (!in_valid || in_acc)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(7) == 0) begin
        in_gap = $urandom_range(12);
        in_valid <= 1'b0;
      end else if (corner_q.size() != 0) begin
        w = corner_q.pop_front();
        in_valid <= 1'b1;
        in_pos_x <= w.x;
        in_pos_y <= w.y;
        in_pos_z <= w.z;
        in_is_target <= w.tgt;
        in_last_corner <= w.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  int out_stall = 0;
  int hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(negedge clk) begin
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(7) == 0) begin
      out_stall = $urandom_range(12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // predictor, monitor and watchdog
  int idle_cyc = 0;
  always @(posedge clk) begin
    normal_t e;
    in_acc = rst_n && in_valid && in_ready;
    if (in_acc) load_corner('{in_pos_x, in_pos_y, in_pos_z, in_is_target, in_last_corner});
    if (rst_n && out_valid && out_ready) begin
      if (normal_q.size() == 0) begin
        report("unexpected word", out_normal_x, 0);
      end else begin
        e = normal_q.pop_front();
        if (out_normal_x !== e.nx) report("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report("normal_y", out_normal_y, e.ny);
        if (out_normal_z !== e.nz) report("normal_z", out_normal_z, e.nz);
      end
    end
    if (in_acc || (out_valid && out_ready) || cfg_we) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc >= WDOG_LIMIT) begin
      $display("weighted_corner_normal_top regression: fail");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [47:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == MODE_IDX) mode_sh = val[1:0];
    else tol_sh = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (corner_q.size() != 0 || in_valid || normal_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic push(int x, int y, int z, bit tgt, bit last);
    corner_q.push_back('{24'(x), 24'(y), 24'(z), tgt, last});
  endtask

  function automatic int rcoord(int kind);
    case (kind)
      0: return $urandom;
      1: return int'($urandom_range(128)) - 64;
      default: return int'($urandom_range(6)) - 3;
    endcase
  endfunction

  // kind 0 full range, 1 small, 2 tight cluster with duplicates
  task automatic rand_facet(int n, int kind);
    int t, bx, by, bz, pick;
    bit tg;
    pick = $urandom_range(19);
    t = $urandom_range(n - 1);
    bx = $urandom; by = $urandom; bz = $urandom;
    for (int i = 0; i < n; i++) begin
      tg = (pick == 0) ? 1'b0 : (pick == 1) ? ($urandom_range(1) == 1) : (i == t);
      if (kind == 2) begin
        if ($urandom_range(2) == 0) push(bx, by, bz, tg, i == n - 1);
        else push(bx + rcoord(2), by + rcoord(2), bz + rcoord(2), tg, i == n - 1);
      end else begin
        push(rcoord(kind), rcoord(kind), rcoord(kind), tg, i == n - 1);
      end
    end
  endtask

  task automatic directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    push(mx, mn, 0, 0, 0); push(mn, mx, mx, 1, 0); push(0, mn, mn, 0, 1);
    push(0, 0, 0, 1, 0); push(4096, 0, 0, 0, 0); push(0, 4096, 0, 0, 1);
    push(0, 0, 0, 0, 0); push(0, 0, 0, 1, 0); push(5, 0, 0, 0, 0);
    push(4096, 4096, 0, 0, 1);
    push(1, 1, 1, 0, 0); push(1, 1, 1, 1, 0); push(1, 1, 1, 0, 0);
    push(2, 1, 1, 0, 1);
    push(7, 7, 7, 0, 1);
    push(3, 0, 0, 0, 0); push(0, 3, 0, 0, 1);
    push(mx, mx, mx, 0, 0); push(mn, mn, mn, 0, 0); push(mx, mn, mx, 0, 1);
    push(-100, 0, 0, 0, 0); push(0, 0, 0, 1, 0); push(100, 1, 0, 0, 1);
    for (int i = 0; i < 20; i++) push(rcoord(1), rcoord(1), rcoord(1), i == 18, i == 19);
  endtask

  task automatic run_phase(logic [1:0] mode, logic [47:0] tol, int facets);
    write_reg(MODE_IDX, {46'd0, mode});
    write_reg(TOL_IDX, tol);
    for (int i = 0; i < facets; i++) begin
      case ($urandom_range(9))
        0: rand_facet($urandom_range(20, 1), $urandom_range(2));
        1, 2, 3: rand_facet($urandom_range(8, 3), 0);
        4, 5: rand_facet($urandom_range(8, 3), 1);
        default: rand_facet($urandom_range(8, 3), 2);
      endcase
    end
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int m = 0; m < 3; m++) begin
      write_reg(MODE_IDX, 48'(m));
      write_reg(TOL_IDX, 48'd20);
      directed();
      wait_idle();
    end
    hold_go = 1'b1;
    run_phase(MODE_UNIFORM, '0, 30);
    run_phase(MODE_AREA, 48'd30, 30);
    run_phase(MODE_ANGLE, TOL_MAX, 30);
    run_phase(MODE_ANGLE, 48'd12, 30);
    run_phase(MODE_UNIFORM, 48'd8000, 30);
    run_phase(MODE_AREA, TOL_MAX, 25);
    quiet = 1'b1;
    run_phase(MODE_ANGLE, '0, 20);
    if (fail_cnt == 0) $display("weighted_corner_normal_top regression: pass");
    else $display("weighted_corner_normal_top regression: fail");
    $finish;
  end

endmodule

FILE: weighted_corner_normal_top.f
hw/rtl/wcn_pkg.sv
hw/rtl/wcn_mac.sv
hw/rtl/wcn_cordic.sv
hw/rtl/weighted_corner_normal_top.sv
verif/tb.sv
